### sv/spq_pkg.sv
`default_nettype none

package spq_pkg;

    // Default sizes of the queue.
    localparam int DEFAULT_CAPACITY    = 16;
    localparam int DEFAULT_VALUE_WIDTH = 32;

    // Fixed widths of the channel fields.
    localparam int CMD_W     = 2;
    localparam int DATA_W    = 32;
    localparam int STATUS_W  = 2;
    localparam int ENTRIES_W = 5;

    // Command codes carried by an input item.
    typedef enum logic [CMD_W-1:0] {
        CMD_ENQUEUE = 2'd0,
        CMD_DEQUEUE = 2'd1,
        CMD_CLEAR   = 2'd2
    } t_cmd;

    // Status codes carried by a result item.
    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } t_status;

    // Control broadcast from the top level to every cell.
    typedef struct packed {
        logic enq;
        logic deq;
    } t_cell_ctrl;

endpackage

`default_nettype wire

### sv/spq_in_if.sv
`default_nettype none

interface spq_in_if import spq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [CMD_W-1:0]         cmd;
    logic [DATA_W-1:0]        item_value;
    logic signed [DATA_W-1:0] item_priority;

    modport source (
        output valid, cmd, item_value, item_priority,
        input  ready
    );

    modport sink (
        input  valid, cmd, item_value, item_priority,
        output ready
    );

endinterface

`default_nettype wire

### sv/spq_out_if.sv
`default_nettype none

interface spq_out_if import spq_pkg::*; ();

    logic                     valid;
    logic                     ready;
    logic [DATA_W-1:0]        taken_value;
    logic signed [DATA_W-1:0] taken_priority;
    logic [STATUS_W-1:0]      status;
    logic [DATA_W-1:0]        front_value;
    logic signed [DATA_W-1:0] front_priority;
    logic [ENTRIES_W-1:0]     entries_held;
    logic                     is_empty;

    modport source (
        output valid, taken_value, taken_priority, status,
               front_value, front_priority, entries_held, is_empty,
        input  ready
    );

    modport sink (
        input  valid, taken_value, taken_priority, status,
               front_value, front_priority, entries_held, is_empty,
        output ready
    );

endinterface

`default_nettype wire

### sv/spq_cell.sv
`default_nettype none

module spq_cell import spq_pkg::*; #(
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic                     i_clk,
    input  wire t_cell_ctrl               i_ctrl,
    input  wire logic                     i_valid,
    input  wire logic                     i_is_tail,
    input  wire logic                     i_left_gt,
    input  wire logic [VALUE_WIDTH-1:0]   i_new_value,
    input  wire logic signed [DATA_W-1:0] i_new_priority,
    input  wire logic [VALUE_WIDTH-1:0]   i_left_value,
    input  wire logic signed [DATA_W-1:0] i_left_priority,
    input  wire logic [VALUE_WIDTH-1:0]   i_right_value,
    input  wire logic signed [DATA_W-1:0] i_right_priority,
    output logic                          o_gt,
    output logic [VALUE_WIDTH-1:0]        o_value,
    output logic signed [DATA_W-1:0]      o_priority
);

    logic [VALUE_WIDTH-1:0]   r_value;
    logic signed [DATA_W-1:0] r_priority;

    // A held entry with a greater priority than the new item must move one place back.
    assign o_gt       = i_valid && (r_priority > i_new_priority);
    assign o_value    = r_value;
    assign o_priority = r_priority;

    // Dequeue shifts toward the head; enqueue shifts toward the tail and
    // drops the new item into the first cell whose entry moves back, or else the tail cell.
    always_ff @(posedge i_clk) begin
        if (i_ctrl.deq) begin
            r_value    <= i_right_value;
            r_priority <= i_right_priority;
        end else if (i_ctrl.enq) begin
            if (i_left_gt) begin
                r_value    <= i_left_value;
                r_priority <= i_left_priority;
            end else if (o_gt || i_is_tail) begin
                r_value    <= i_new_value;
                r_priority <= i_new_priority;
            end
        end
    end

endmodule

`default_nettype wire

### sv/sorted_priority_queue_unit.sv
`default_nettype none

// Sorted priority queue of CAPACITY entries built as a row of cells, one
// entry per cell, kept in ascending priority order with the head in cell 0.
// Each input item carries a command: enqueue inserts behind every entry of
// lower or equal priority (equal priorities leave in arrival order), dequeue
// removes the head, clear empties the queue. Every item gives exactly one
// result item with the removed entry, a status code and the head, count and
// empty flag after the command. An item is accepted in every cycle in which
// the result register is free or being emptied, and its result appears in
// the cycle after acceptance: one item per cycle, set by the cell row, which
// compares and shifts every slot in the same cycle. Slots need no clearing
// after reset; only the entry count and the result valid flag are reset.
module sorted_priority_queue_unit import spq_pkg::*; #(
    parameter int CAPACITY    = DEFAULT_CAPACITY,
    parameter int VALUE_WIDTH = DEFAULT_VALUE_WIDTH
) (
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    spq_in_if.sink     i_in,
    spq_out_if.source  o_out
);

    localparam int CNT_W = $clog2(CAPACITY + 1);

    logic [CNT_W-1:0]         r_count;
    logic [CNT_W-1:0]         n_count;
    logic                     r_out_valid;
    logic                     n_out_valid;
    logic [DATA_W-1:0]        r_taken_value;
    logic signed [DATA_W-1:0] r_taken_priority;
    t_status                  r_status;
    logic [DATA_W-1:0]        r_front_value;
    logic signed [DATA_W-1:0] r_front_priority;
    logic [ENTRIES_W-1:0]     r_entries;
    logic                     r_empty;

    logic                     w_accept;
    logic                     w_full;
    logic                     w_enq_ok;
    logic                     w_deq_ok;
    t_status                  w_status;
    t_cell_ctrl               w_ctrl;
    logic [VALUE_WIDTH-1:0]   w_new_value;
    logic [VALUE_WIDTH-1:0]   w_head_value;
    logic signed [DATA_W-1:0] w_head_priority;

    logic [VALUE_WIDTH-1:0]   w_value    [CAPACITY];
    logic signed [DATA_W-1:0] w_priority [CAPACITY];
    logic                     w_gt       [CAPACITY];

    // Handshake: the result register parts the two sides.
    assign i_in.ready  = !r_out_valid || o_out.ready;
    assign w_accept    = i_in.valid && i_in.ready;
    assign n_out_valid = w_accept || (r_out_valid && !o_out.ready);

    assign w_full      = (r_count == CNT_W'(CAPACITY));
    assign w_new_value = VALUE_WIDTH'(i_in.item_value);

    // Command decode.
    always_comb begin
        w_enq_ok = 1'b0;
        w_deq_ok = 1'b0;
        w_status = ST_OK;
        n_count  = r_count;
        unique case (t_cmd'(i_in.cmd))
            CMD_ENQUEUE: begin
                if (w_full) begin
                    w_status = ST_FULL;
                end else begin
                    w_enq_ok = 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end
            CMD_DEQUEUE: begin
                if (r_count == '0) begin
                    w_status = ST_EMPTY;
                end else begin
                    w_deq_ok = 1'b1;
                    n_count  = r_count - 1'b1;
                end
            end
            CMD_CLEAR: begin
                n_count = '0;
            end
            default: begin
            end
        endcase
    end

    assign w_ctrl.enq = w_accept && w_enq_ok;
    assign w_ctrl.deq = w_accept && w_deq_ok;

    // Row of cells, each linked to its neighbors; cell 0 takes the new item on its left.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [VALUE_WIDTH-1:0]   w_left_value;
        logic signed [DATA_W-1:0] w_left_priority;
        logic                     w_left_gt;
        logic [VALUE_WIDTH-1:0]   w_right_value;
        logic signed [DATA_W-1:0] w_right_priority;

        if (g == 0) begin : g_first
            assign w_left_value    = w_new_value;
            assign w_left_priority = i_in.item_priority;
            assign w_left_gt       = 1'b0;
        end else begin : g_inner
            assign w_left_value    = w_value[g-1];
            assign w_left_priority = w_priority[g-1];
            assign w_left_gt       = w_gt[g-1];
        end

        if (g == CAPACITY - 1) begin : g_last
            assign w_right_value    = w_value[g];
            assign w_right_priority = w_priority[g];
        end else begin : g_mid
            assign w_right_value    = w_value[g+1];
            assign w_right_priority = w_priority[g+1];
        end

        spq_cell #(
            .VALUE_WIDTH (VALUE_WIDTH)
        ) u_cell (
            .i_clk            (i_clk),
            .i_ctrl           (w_ctrl),
            .i_valid          (CNT_W'(g) < r_count),
            .i_is_tail        (CNT_W'(g) == r_count),
            .i_left_gt        (w_left_gt),
            .i_new_value      (w_new_value),
            .i_new_priority   (i_in.item_priority),
            .i_left_value     (w_left_value),
            .i_left_priority  (w_left_priority),
            .i_right_value    (w_right_value),
            .i_right_priority (w_right_priority),
            .o_gt             (w_gt[g]),
            .o_value          (w_value[g]),
            .o_priority       (w_priority[g])
        );
    end

    // Head after the command, read from the same inputs that cell 0 uses.
    always_comb begin
        if (w_deq_ok) begin
            w_head_value    = w_value[1];
            w_head_priority = w_priority[1];
        end else if (w_enq_ok && (w_gt[0] || (r_count == '0))) begin
            w_head_value    = w_new_value;
            w_head_priority = i_in.item_priority;
        end else begin
            w_head_value    = w_value[0];
            w_head_priority = w_priority[0];
        end
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count <= n_count;
            end
            r_out_valid <= n_out_valid;
        end
    end

    // Result register.
    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_taken_value    <= w_deq_ok ? DATA_W'(w_value[0]) : '0;
            r_taken_priority <= w_deq_ok ? w_priority[0] : '0;
            r_status         <= w_status;
            r_front_value    <= (n_count != '0) ? DATA_W'(w_head_value) : '0;
            r_front_priority <= (n_count != '0) ? w_head_priority : '0;
            r_entries        <= ENTRIES_W'(n_count);
            r_empty          <= (n_count == '0);
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.taken_value    = r_taken_value;
    assign o_out.taken_priority = r_taken_priority;
    assign o_out.status         = r_status;
    assign o_out.front_value    = r_front_value;
    assign o_out.front_priority = r_front_priority;
    assign o_out.entries_held   = r_entries;
    assign o_out.is_empty       = r_empty;

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CNT_W'(CAPACITY))
        else $error("entry count exceeds capacity");

    // A dequeue removes exactly one entry.
    a_deq_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_ctrl.deq |=> (r_count == $past(r_count) - 1'b1))
        else $error("dequeue did not remove one entry");

    // The two front cells stay in priority order.
    a_head_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count >= CNT_W'(2)) |-> (w_priority[0] <= w_priority[1]))
        else $error("front cells out of priority order");

endmodule

`default_nettype wire
